// ----- hw/rtl/agb_pkg.sv -----
// Shared commands, constants and color helper functions for the glyph blitter.
`timescale 1ns / 1ps

package agb_pkg;

	// Command codes carried on the input tuser.
	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_GLYPH = 2'd1,
		CMD_BYTE  = 2'd2
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic {
		CFG_FORE = 1'b0,
		CFG_BACK = 1'b1
	} cfg_reg_t;

	// Input tdata layout, lowest bit first.
	localparam int IN_W        = 88;
	localparam int PEN_LSB     = 0;
	localparam int BASE_LSB    = 18;
	localparam int OFFX_LSB    = 30;
	localparam int OFFY_LSB    = 38;
	localparam int COLS_LSB    = 46;
	localparam int ROWS_LSB    = 53;
	localparam int ADV_LSB     = 60;
	localparam int BITS_LSB    = 73;

	// Fixed arithmetic constants.
	localparam logic signed [18:0] HALF_PX   = 19'sd32;
	localparam logic signed [18:0] PEN_MAX   = 19'sd131071;
	localparam logic [3:0]         ALPHA_MAX = 4'd15;
	localparam logic [9:0]         MIX_ROUND = 10'd7;
	localparam logic [21:0]        DIV15_MUL = 22'd2185;
	localparam int                 DIV15_SH  = 15;

	// Weighted channel sum before the divide by 15: f*a + b*(15-a) + 7.
	function automatic logic [9:0] mix_sum(input logic [5:0] f, input logic [5:0] b,
		input logic [3:0] a);
		logic [9:0] fa;
		logic [9:0] ba;
		fa = 10'(f) * 10'(a);
		ba = 10'(b) * 10'(ALPHA_MAX - a);
		return fa + ba + MIX_ROUND;
	endfunction

	// Exact x / 15 for x up to 952 by a reciprocal multiply.
	function automatic logic [5:0] div15(input logic [9:0] x);
		logic [21:0] p;
		p = 22'(x) * DIV15_MUL;
		return p[DIV15_SH +: 6];
	endfunction

endpackage

// ----- hw/rtl/antialiased_glyph_blitter.sv -----
// Anti-aliased 4-bit glyph blitter producing RGB565 pixel writes.
`timescale 1ns / 1ps

// Usage:
// The input stream carries one command per item; tuser holds the command
// (start of a text run, glyph header or packed bitmap byte) and tdata the
// operand fields. Start and header items only update the pen and glyph
// placement state. Each bitmap byte holds two 4-bit alphas, high nibble
// first, and gives zero, one or two pixel items on the output stream;
// tlast marks the final pixel of a byte. Pixels with zero alpha are skipped.
// Colors come from the fore_color and back_color registers, written on the
// cfg port while the stream is idle.
// A pixel goes from its byte to the output through the holding stage
// (placement and channel sums) and the output register (divide by 15).
// Throughput: one header or start item per cycle and one byte per cycle
// when it gives at most one pixel, while the output does not stall; a byte
// with two pixels holds off the next item until its first pixel moves on.
// Reset clears the pen, glyph state, colors and all pending pixels. When the
// receiver stalls, the output register holds its pixel, the two-pixel
// holding stage fills, and s_tready drops until space frees up.
module antialiased_glyph_blitter #(
	parameter int MAX_GLYPH_DIM = 64,
	parameter int COORD_BITS    = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input stream.
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// tdata: start_pen_x64[17:0], baseline[29:18], offset_x[37:30], offset_y[45:38],
	// glyph_cols[52:46], glyph_rows[59:53], pen_step[72:60], packed_bits[80:73]
	input  logic [agb_pkg::IN_W-1:0]    s_tdata,
	// tuser: cmd
	input  logic [1:0]                  s_tuser,
	// Output stream.
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// tdata: pixel_x, pixel_y, pixel_color (from the lowest bit up), zero padded
	output logic [((2*COORD_BITS+16+7)/8)*8-1:0] m_tdata,
	// tlast: last pixel of the byte
	output logic                        m_tlast,
	// Configuration write port.
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [15:0]                 cfg_wdata
);

	localparam int OUT_W  = ((2*COORD_BITS+16+7)/8)*8;
	localparam int DIM_W  = $clog2(MAX_GLYPH_DIM + 1);
	localparam int CNT_W  = 2 * DIM_W;
	localparam int LEFT_W = 14;
	localparam int TOP_W  = 13;
	localparam int PX_W   = ((LEFT_W > DIM_W + 1) ? LEFT_W : DIM_W + 1) + 1;
	localparam int CMAX   = (1 << (COORD_BITS - 1)) - 1;
	localparam int CMIN   = -CMAX - 1;

	// One pixel waiting for the divide stage.
	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [9:0]                   mr;
		logic [9:0]                   mg;
		logic [9:0]                   mb;
		logic                         last;
	} pix_t;

	// One finished pixel in the output register.
	typedef struct packed {
		logic [15:0]                  color;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] x;
		logic                         last;
	} out_t;

	function automatic logic signed [COORD_BITS-1:0] sat_coord(
		input logic signed [PX_W-1:0] v);
		logic signed [COORD_BITS-1:0] r;
		if (int'(v) > CMAX) begin
			r = COORD_BITS'(CMAX);
		end else if (int'(v) < CMIN) begin
			r = COORD_BITS'(CMIN);
		end else begin
			r = COORD_BITS'(v);
		end
		return r;
	endfunction

	// Field extraction.
	logic [1:0]         in_cmd;
	logic signed [17:0] in_pen;
	logic signed [11:0] in_base;
	logic signed [7:0]  in_offx;
	logic signed [7:0]  in_offy;
	logic [6:0]         in_cols;
	logic [6:0]         in_rows;
	logic [12:0]        in_adv;
	logic [7:0]         in_bits;

	assign in_cmd  = s_tuser;
	assign in_pen  = s_tdata[agb_pkg::PEN_LSB +: 18];
	assign in_base = s_tdata[agb_pkg::BASE_LSB +: 12];
	assign in_offx = s_tdata[agb_pkg::OFFX_LSB +: 8];
	assign in_offy = s_tdata[agb_pkg::OFFY_LSB +: 8];
	assign in_cols = s_tdata[agb_pkg::COLS_LSB +: 7];
	assign in_rows = s_tdata[agb_pkg::ROWS_LSB +: 7];
	assign in_adv  = s_tdata[agb_pkg::ADV_LSB +: 13];
	assign in_bits = s_tdata[agb_pkg::BITS_LSB +: 8];

	// Architectural state.
	logic [15:0]              fore_q;
	logic [15:0]              back_q;
	logic signed [17:0]       pen_q;
	logic signed [11:0]       base_q;
	logic signed [LEFT_W-1:0] left_q;
	logic signed [TOP_W-1:0]  top_q;
	logic [DIM_W-1:0]         cols_q;
	logic [CNT_W-1:0]         pix_left_q;
	logic [DIM_W-1:0]         col_q;
	logic [DIM_W-1:0]         row_q;

	// Pipeline registers.
	pix_t       slot0_s1;
	pix_t       slot1_s1;
	logic [1:0] cnt_s1;
	out_t       out_s2;
	logic       vld_s2;

	// Handshake control.
	logic out_free;
	logic move;
	logic acc;
	logic byte_acc;

	assign out_free = !vld_s2 || m_tready;
	assign move     = (cnt_s1 != 2'd0) && out_free;
	assign s_tready = (cnt_s1 == 2'd0) || ((cnt_s1 == 2'd1) && move);
	assign acc      = s_tvalid && s_tready;
	assign byte_acc = acc && (in_cmd == agb_pkg::CMD_BYTE);

	// Glyph placement: round the pen to whole pixels, truncating toward zero.
	logic signed [18:0]       pen_rnd;
	logic signed [12:0]       pen_px;
	logic signed [LEFT_W-1:0] left_d;
	logic signed [TOP_W-1:0]  top_d;
	logic [DIM_W-1:0]         cols_d;
	logic [DIM_W-1:0]         rows_d;
	logic signed [18:0]       pen_adv;
	logic signed [17:0]       pen_d;

	always_comb begin
		pen_rnd = 19'(pen_q) + agb_pkg::HALF_PX;
		pen_px  = 13'(pen_rnd >>> 6);
		if (pen_rnd[18] && (pen_rnd[5:0] != 6'd0)) begin
			pen_px = pen_px + 13'sd1;
		end
		left_d  = LEFT_W'(pen_px) + LEFT_W'(in_offx);
		top_d   = TOP_W'(base_q) + TOP_W'(in_offy);
		cols_d  = (int'(in_cols) > MAX_GLYPH_DIM) ? DIM_W'(MAX_GLYPH_DIM) : DIM_W'(in_cols);
		rows_d  = (int'(in_rows) > MAX_GLYPH_DIM) ? DIM_W'(MAX_GLYPH_DIM) : DIM_W'(in_rows);
		pen_adv = 19'(pen_q) + 19'({6'b0, in_adv});
		pen_d   = (pen_adv > agb_pkg::PEN_MAX) ? 18'(agb_pkg::PEN_MAX) : 18'(pen_adv);
	end

	// Raster walk for the two nibbles of a byte.
	logic             step0;
	logic             step1;
	logic             wrap0;
	logic             wrap1;
	logic [DIM_W-1:0] col1;
	logic [DIM_W-1:0] row1;
	logic [DIM_W-1:0] col2;
	logic [DIM_W-1:0] row2;

	always_comb begin
		step0 = pix_left_q != CNT_W'(0);
		step1 = pix_left_q > CNT_W'(1);
		wrap0 = ({1'b0, col_q} + (DIM_W+1)'(1)) >= {1'b0, cols_q};
		col1  = wrap0 ? DIM_W'(0) : col_q + DIM_W'(1);
		row1  = wrap0 ? row_q + DIM_W'(1) : row_q;
		wrap1 = ({1'b0, col1} + (DIM_W+1)'(1)) >= {1'b0, cols_q};
		col2  = wrap1 ? DIM_W'(0) : col1 + DIM_W'(1);
		row2  = wrap1 ? row1 + DIM_W'(1) : row1;
	end

	// Pixel coordinates, channel sums and compaction of emitted pixels.
	logic [3:0]             a0;
	logic [3:0]             a1;
	logic                   emit0;
	logic                   emit1;
	logic signed [PX_W-1:0] px0;
	logic signed [PX_W-1:0] py0;
	logic signed [PX_W-1:0] px1;
	logic signed [PX_W-1:0] py1;
	pix_t                   pix0;
	pix_t                   pix1;
	logic [1:0]             n_new;

	always_comb begin
		a0    = in_bits[7:4];
		a1    = in_bits[3:0];
		emit0 = step0 && (a0 != 4'd0);
		emit1 = step1 && (a1 != 4'd0);
		px0   = PX_W'(left_q) + PX_W'({1'b0, col_q});
		py0   = PX_W'(top_q) + PX_W'({1'b0, row_q});
		px1   = PX_W'(left_q) + PX_W'({1'b0, col1});
		py1   = PX_W'(top_q) + PX_W'({1'b0, row1});

		pix0.x    = sat_coord(px0);
		pix0.y    = sat_coord(py0);
		pix0.mr   = agb_pkg::mix_sum({1'b0, fore_q[15:11]}, {1'b0, back_q[15:11]}, a0);
		pix0.mg   = agb_pkg::mix_sum(fore_q[10:5], back_q[10:5], a0);
		pix0.mb   = agb_pkg::mix_sum({1'b0, fore_q[4:0]}, {1'b0, back_q[4:0]}, a0);
		pix0.last = !emit1;

		pix1.x    = sat_coord(px1);
		pix1.y    = sat_coord(py1);
		pix1.mr   = agb_pkg::mix_sum({1'b0, fore_q[15:11]}, {1'b0, back_q[15:11]}, a1);
		pix1.mg   = agb_pkg::mix_sum(fore_q[10:5], back_q[10:5], a1);
		pix1.mb   = agb_pkg::mix_sum({1'b0, fore_q[4:0]}, {1'b0, back_q[4:0]}, a1);
		pix1.last = 1'b1;

		n_new = 2'(emit0) + 2'(emit1);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fore_q <= '0;
			back_q <= '0;
		end else if (cfg_we) begin
			unique case (agb_pkg::cfg_reg_t'(cfg_index))
				agb_pkg::CFG_FORE: fore_q <= cfg_wdata;
				agb_pkg::CFG_BACK: back_q <= cfg_wdata;
			endcase
		end
	end

	// Pen and glyph state, updated as each item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_q      <= '0;
			base_q     <= '0;
			left_q     <= '0;
			top_q      <= '0;
			cols_q     <= '0;
			pix_left_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (acc) begin
			unique case (in_cmd)
				agb_pkg::CMD_START: begin
					pen_q      <= in_pen;
					base_q     <= in_base;
					pix_left_q <= '0;
					col_q      <= '0;
					row_q      <= '0;
				end
				agb_pkg::CMD_GLYPH: begin
					left_q     <= left_d;
					top_q      <= top_d;
					cols_q     <= cols_d;
					pix_left_q <= CNT_W'(cols_d) * CNT_W'(rows_d);
					col_q      <= '0;
					row_q      <= '0;
					pen_q      <= pen_d;
				end
				agb_pkg::CMD_BYTE: begin
					if (step1) begin
						pix_left_q <= pix_left_q - CNT_W'(2);
						col_q      <= col2;
						row_q      <= row2;
					end else if (step0) begin
						pix_left_q <= pix_left_q - CNT_W'(1);
						col_q      <= col1;
						row_q      <= row1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Holding stage: up to two pixels of one byte, oldest in slot 0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= 2'd0;
		end else if (byte_acc) begin
			cnt_s1 <= n_new;
		end else if (move) begin
			cnt_s1 <= cnt_s1 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_acc) begin
			slot0_s1 <= emit0 ? pix0 : pix1;
			slot1_s1 <= pix1;
		end else if (move) begin
			slot0_s1 <= slot1_s1;
		end
	end

	// Output register: divide the channel sums by 15 and pack RGB565.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (move) begin
			vld_s2 <= 1'b1;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	logic [5:0] div_r;
	logic [5:0] div_g;
	logic [5:0] div_b;

	assign div_r = agb_pkg::div15(slot0_s1.mr);
	assign div_g = agb_pkg::div15(slot0_s1.mg);
	assign div_b = agb_pkg::div15(slot0_s1.mb);

	always_ff @(posedge clk) begin
		if (move) begin
			out_s2.x     <= slot0_s1.x;
			out_s2.y     <= slot0_s1.y;
			out_s2.color <= {div_r[4:0], div_g, div_b[4:0]};
			out_s2.last  <= slot0_s1.last;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tlast  = out_s2.last;
	assign m_tdata  = OUT_W'({out_s2.color, out_s2.y, out_s2.x});

	// The holding stage never counts past the two pixels of a byte.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_s1 <= 2'd2)
		else $error("holding stage count out of range");

	// A pixel that is not the last of its byte always has its partner pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !out_s2.last) |-> (cnt_s1 != 2'd0))
		else $error("second pixel of a byte missing");

	// Pending glyph pixels imply a glyph with nonzero width.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pix_left_q != CNT_W'(0)) |-> (cols_q != DIM_W'(0)))
		else $error("pixels pending for an empty glyph");

	// A start item drops any glyph in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (in_cmd == agb_pkg::CMD_START)) |=> (pix_left_q == CNT_W'(0)))
		else $error("start item did not drop the glyph");

endmodule
